// File: hw/rtl/packed_sample_store_top_defines.svh
// ----------------------------------------------------------------------------
// packed sample store assertion macros
// shared property forms for the checker of the packed sample store
// ----------------------------------------------------------------------------
`ifndef PACKED_SAMPLE_STORE_TOP_DEFINES_SVH
`define PACKED_SAMPLE_STORE_TOP_DEFINES_SVH

// consequent in the same cycle
`define PSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// packed sample store package
// word types, codes and lookup tables of the packed sample store
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int STORE_WORDS_DEF     = 4096;
  localparam int MAX_SAMPLE_BITS_DEF = 32;
  localparam int RECIP_SHIFT         = 22;

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_VALUE = 2'd1;
  localparam logic [1:0] ERR_POS   = 2'd2;

  localparam logic [0:0] REG_SAMPLE_BITS = 1'd0;
  localparam logic [0:0] REG_WORD_SIZE   = 1'd1;

  localparam logic [1:0] WS_8  = 2'd0;
  localparam logic [1:0] WS_16 = 2'd1;
  localparam logic [1:0] WS_32 = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [16:0] sample_pos;
    logic [31:0] write_value;
  } pss_cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  error_code;
  } pss_rsp_t;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return (n >= 6'd32) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  // samples per 32-bit word
  function automatic logic [5:0] per_word_32(input logic [5:0] b);
    logic [5:0] r;
    case (b) inside
      6'd1:             r = 6'd32;
      6'd2:             r = 6'd16;
      6'd3:             r = 6'd10;
      6'd4:             r = 6'd8;
      6'd5:             r = 6'd6;
      6'd6:             r = 6'd5;
      [6'd7:6'd8]:      r = 6'd4;
      [6'd9:6'd10]:     r = 6'd3;
      [6'd11:6'd16]:    r = 6'd2;
      [6'd17:6'd32]:    r = 6'd1;
      default:          r = 6'd1;
    endcase
    return r;
  endfunction

  // ceil(2^22 / d), exact quotient for 17-bit dividends
  function automatic logic [22:0] recip(input logic [5:0] d);
    logic [22:0] r;
    unique case (d)
      6'd1:    r = 23'd4194304;
      6'd2:    r = 23'd2097152;
      6'd3:    r = 23'd1398102;
      6'd4:    r = 23'd1048576;
      6'd5:    r = 23'd838861;
      6'd6:    r = 23'd699051;
      6'd7:    r = 23'd599187;
      6'd8:    r = 23'd524288;
      6'd9:    r = 23'd466034;
      6'd10:   r = 23'd419431;
      6'd11:   r = 23'd381301;
      6'd12:   r = 23'd349526;
      6'd13:   r = 23'd322639;
      6'd14:   r = 23'd299594;
      6'd15:   r = 23'd279621;
      6'd16:   r = 23'd262144;
      6'd17:   r = 23'd246724;
      6'd18:   r = 23'd233017;
      6'd19:   r = 23'd220753;
      6'd20:   r = 23'd209716;
      6'd21:   r = 23'd199729;
      6'd22:   r = 23'd190651;
      6'd23:   r = 23'd182362;
      6'd24:   r = 23'd174763;
      6'd25:   r = 23'd167773;
      6'd26:   r = 23'd161320;
      6'd27:   r = 23'd155345;
      6'd28:   r = 23'd149797;
      6'd29:   r = 23'd144632;
      6'd30:   r = 23'd139811;
      6'd31:   r = 23'd135301;
      6'd32:   r = 23'd131072;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/pss_stream_if.sv
// ----------------------------------------------------------------------------
// packed sample store stream channel
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface pss_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/pss_ram.sv
// ----------------------------------------------------------------------------
// packed sample store ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/packed_sample_store_top.sv
// ----------------------------------------------------------------------------
// packed sample store
// reads or writes one bit-packed sample per command word in a word store
//
// cmd carries opcode, sample_pos and write_value; rsp returns read_value and
// error_code, one rsp word per cmd word, in order. sample_bits and
// word_size_code are set through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// One command is in flight at a time. Each passes the divide, quotient and
// address steps; a wide read repeats the read and modify steps for every word
// and a wide write writes each further word in a write step, as every word
// uses the single read and write port of the store ram. A rejected command
// goes from the address step to the finish step. Position to word index goes
// through a reciprocal multiply and a remainder multiply, one registered stage
// each. After reset the store is cleared one word per cycle, all STORE_WORDS
// words, with cmd.ready low; configuration writes are taken meanwhile.
// A finished rsp word waits in the output register while the receiver stalls;
// the next command is accepted meanwhile and holds in its last step until
// the output register frees.
// ----------------------------------------------------------------------------
module packed_sample_store_top import pss_pkg::*; #(
  parameter int STORE_WORDS     = STORE_WORDS_DEF,
  parameter int MAX_SAMPLE_BITS = MAX_SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [5:0]   cfg_data,
  pss_stream_if.sink   cmd,
  pss_stream_if.source rsp
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int CW = ($clog2(STORE_WORDS + 1) > 20) ? $clog2(STORE_WORDS + 1) : 20;
  localparam logic [5:0]    MAX_B     = 6'(MAX_SAMPLE_BITS);
  localparam logic [CW-1:0] SW_LIM    = CW'(STORE_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_QUO   = 9'b000001000,
    S_ADDR  = 9'b000010000,
    S_RD    = 9'b000100000,
    S_MOD   = 9'b001000000,
    S_WR    = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t        state;
  logic [5:0]    sample_bits;
  logic [1:0]    word_size;
  logic [AW-1:0] clr_addr;
  logic          out_valid;
  pss_rsp_t      out_data;

  logic          op;
  logic [16:0]   pos;
  logic [31:0]   val;
  logic [5:0]    b;
  logic [1:0]    wc;
  logic [39:0]   prod;
  logic [16:0]   quo;
  logic [4:0]    rem;
  logic [4:0]    sh;
  logic [AW-1:0] base;
  logic [1:0]    cnt;
  logic [1:0]    nlast;
  logic [31:0]   acc;
  logic [31:0]   res;
  logic [1:0]    err;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          cmd_acc;
  logic          out_free;
  logic [5:0]    w_bits;
  logic [31:0]   smask;
  logic [31:0]   wmask;
  logic          narrow;
  logic [5:0]    spw;
  logic [22:0]   recip_m;
  logic [16:0]   q_c;
  logic [22:0]   qspw;
  logic [4:0]    rem_c;
  logic [11:0]   shp;
  logic [1:0]    nlast_c;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] first_c;
  logic [CW-1:0] last_c;
  logic          err_val;
  logic          err_pos;
  logic [31:0]   rdata_m;
  logic [31:0]   m_n;
  logic [31:0]   new_n;
  logic [31:0]   read_n;
  logic [31:0]   acc_n;
  logic [6:0]    top_off;
  logic [5:0]    topbits;
  logic [31:0]   pmask;
  logic [31:0]   new_w;
  logic [1:0]    dk;
  logic [6:0]    lo_off;
  logic [31:0]   wr_word;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign out_free  = !out_valid || rsp.ready;

  assign w_bits  = 6'd8 << wc;
  assign smask   = low_mask(b);
  assign wmask   = low_mask(w_bits);
  assign narrow  = (b < w_bits);
  assign spw     = per_word_32(b) >> (2'd2 - wc);
  assign recip_m = recip(spw);

  assign q_c   = prod[RECIP_SHIFT +: 17];
  assign qspw  = 23'(q_c) * 23'(spw);
  assign rem_c = 5'(23'(pos) - qspw);
  assign shp   = 12'(spw - 6'd1 - 6'(rem)) * 12'(b);

  assign nlast_c = 2'((b - 6'd1) >> (3'd3 + 3'(wc)));
  assign pos_w   = CW'(pos);

  always_comb begin
    case (nlast_c)
      2'd0:    first_c = pos_w;
      2'd1:    first_c = pos_w << 1;
      2'd2:    first_c = pos_w + (pos_w << 1);
      default: first_c = pos_w << 2;
    endcase
  end

  assign last_c  = first_c + CW'(nlast_c);
  assign err_val = (op == OP_WRITE) && (val > smask);
  assign err_pos = narrow ? (CW'(quo) >= SW_LIM) : (last_c >= SW_LIM);

  assign rdata_m = ram_rdata & wmask;
  assign m_n     = (smask << sh) & wmask;
  assign new_n   = ((rdata_m & ~m_n) | ((val << sh) & m_n)) & wmask;
  assign read_n  = (rdata_m >> sh) & smask;
  assign acc_n   = (acc << w_bits) | rdata_m;

  assign top_off = 7'({nlast, 3'b000}) << wc;
  assign topbits = b - 6'(top_off);
  assign pmask   = low_mask(topbits);
  assign new_w   = ((rdata_m & ~pmask) | ((val >> top_off) & pmask)) & wmask;

  assign dk      = nlast - cnt;
  assign lo_off  = 7'({dk, 3'b000}) << wc;
  assign wr_word = (val >> lo_off) & wmask;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base;
    ram_wdata = new_n;
    ram_re    = 1'b0;
    ram_raddr = base + AW'(cnt);
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 32'd0;
      end
      S_RD: begin
        ram_re = 1'b1;
      end
      S_MOD: begin
        ram_we    = (op == OP_WRITE);
        ram_wdata = narrow ? new_n : new_w;
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = base + AW'(cnt);
        ram_wdata = wr_word;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      sample_bits <= 6'd8;
      word_size   <= WS_8;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_BITS: sample_bits <= cfg_data;
          REG_WORD_SIZE:   word_size   <= cfg_data[1:0];
        endcase
      end
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_QUO;
        S_QUO: state <= S_ADDR;
        S_ADDR: begin
          if (err_val || (b == 6'd0) || err_pos) begin
            state <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_MOD;
        S_MOD: begin
          if (narrow) begin
            state <= S_FIN;
          end else if (op == OP_READ) begin
            state <= (cnt == nlast) ? S_FIN : S_RD;
          end else begin
            state <= (nlast == 2'd0) ? S_FIN : S_WR;
          end
        end
        S_WR: begin
          if (cnt == nlast) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op  <= cmd.data.opcode;
        pos <= cmd.data.sample_pos;
        val <= cmd.data.write_value;
        b   <= (sample_bits > MAX_B) ? MAX_B : sample_bits;
        wc  <= (word_size > WS_32) ? WS_32 : word_size;
        err <= ERR_NONE;
        res <= 32'd0;
        acc <= 32'd0;
        cnt <= 2'd0;
      end
      S_DIV: begin
        prod <= 40'(pos) * 40'(recip_m);
      end
      S_QUO: begin
        quo <= q_c;
        rem <= rem_c;
      end
      S_ADDR: begin
        sh    <= shp[4:0];
        nlast <= narrow ? 2'd0 : nlast_c;
        base  <= narrow ? AW'(quo) : AW'(first_c);
        if (err_val) begin
          err <= ERR_VALUE;
        end else if ((b != 6'd0) && err_pos) begin
          err <= ERR_POS;
        end
      end
      S_MOD: begin
        if (narrow) begin
          if (op == OP_READ) begin
            res <= read_n;
          end
        end else if (op == OP_READ) begin
          acc <= acc_n;
          if (cnt == nlast) begin
            res <= acc_n & smask;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end else begin
          cnt <= 2'd1;
        end
      end
      S_WR: begin
        cnt <= cnt + 2'd1;
      end
      S_FIN: begin
        if (out_free) begin
          out_data.read_value <= res;
          out_data.error_code <= err;
        end
      end
      default: begin
      end
    endcase
  end

  pss_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: hw/rtl/pss_checker.sv
// ----------------------------------------------------------------------------
// packed sample store checker
// port level checks on the command and response channels
// ----------------------------------------------------------------------------
`include "packed_sample_store_top_defines.svh"

module pss_checker import pss_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input pss_rsp_t rsp_data
);

  `PSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word dropped or changed while stalled")

  `PSS_ASSERT_SAME(a_err_zero, rsp_valid && (rsp_data.error_code != ERR_NONE), rsp_data.read_value == 32'd0, "rejected command returned a nonzero sample")

  `PSS_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready, "second command taken while one is in flight")

endmodule

bind packed_sample_store_top pss_checker u_pss_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
